// File: rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

  // Ring store geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam logic signed [DATA_W-1:0] NEG_ONE = '1;

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } sts_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_ACCESS = 2'd1,
    S_REPLY  = 2'd2
  } state_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    sts_t                     status;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the input item
    logic exec;     // access the store and update the pointers
    logic sel_ram;  // drive the result from the store read data
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_hit;  // last operation was a pop that removed an entry
  } dq_sts_t;

endpackage

// File: rtl/double_ended_queue.sv
`timescale 1ns / 1ps

// Channel   Ports                     Transfer when
// input     start, busy, in_item      start high and busy low at a clock edge
// result    out_valid, out_item       out_valid high (a one-cycle strobe per result)
//
// Each operation runs in three steps: capture, one store access through the
// single port of the ring RAM with the pointer update, and the result cycle
// in which the registered read data is shown. A new operation is taken the
// cycle after the result. Reset (rst_n, synchronous, active low) empties the
// queue; store contents are not cleared. The receiver cannot stall: each
// result is on out_item for exactly one cycle with out_valid high.

module double_ended_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dq_pkg::in_item_t  in_item,
  output logic              out_valid,
  output dq_pkg::out_item_t out_item
);

  dq_pkg::dq_cmd_t cmd;
  dq_pkg::dq_sts_t dp_sts;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .dp_sts    (dp_sts),
    .cmd       (cmd)
  );

  dq_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .dp_sts   (dp_sts),
    .out_item (out_item)
  );

endmodule

// File: rtl/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  input  dq_pkg::dq_sts_t dp_sts,
  output dq_pkg::dq_cmd_t cmd
);

  dq_pkg::state_t state_r;
  dq_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dq_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = dq_pkg::S_ACCESS;
        end
      end
      dq_pkg::S_ACCESS: state_nxt = dq_pkg::S_REPLY;
      dq_pkg::S_REPLY:  state_nxt = dq_pkg::S_IDLE;
      default:          state_nxt = dq_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      dq_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      dq_pkg::S_ACCESS: begin
        cmd.exec = 1'b1;
      end
      dq_pkg::S_REPLY: begin
        out_valid   = 1'b1;
        cmd.sel_ram = dp_sts.pop_hit;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // Every transfer in yields a result after the access state
  a_reply_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing after transfer");

  // Busy only drops right after a result
  a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> $past(out_valid))
    else $error("busy dropped without a result");

  // Store read data is selected only while a result is shown
  a_sel_in_reply: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sel_ram |-> (out_valid && busy))
    else $error("store data selected outside result cycle");
`endif

endmodule

// File: rtl/dq_datapath.sv
`timescale 1ns / 1ps

module dq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  dq_pkg::in_item_t   in_item,
  input  dq_pkg::dq_cmd_t    cmd,
  output dq_pkg::dq_sts_t    dp_sts,
  output dq_pkg::out_item_t  out_item
);

  localparam dq_pkg::idx_t IDX_LAST = dq_pkg::IDX_W'(dq_pkg::CAPACITY - 1);
  localparam dq_pkg::cnt_t CNT_FULL = dq_pkg::CNT_W'(dq_pkg::CAPACITY);
  localparam logic [dq_pkg::CNT_W:0] SUM_CAP = (dq_pkg::CNT_W + 1)'(dq_pkg::CAPACITY);

  dq_pkg::op_t                      op_r;
  logic signed [dq_pkg::DATA_W-1:0] value_r;
  dq_pkg::idx_t                     front_r;
  dq_pkg::idx_t                     front_nxt;
  dq_pkg::cnt_t                     count_r;
  dq_pkg::cnt_t                     count_nxt;
  dq_pkg::sts_t                     sts_r;
  dq_pkg::sts_t                     sts_nxt;

  logic                             empty;
  logic                             full;
  dq_pkg::idx_t                     front_dec;
  dq_pkg::idx_t                     front_inc;
  logic [dq_pkg::CNT_W:0]           tail_sum;
  logic [dq_pkg::CNT_W:0]           back_sum;
  dq_pkg::idx_t                     tail_slot;
  dq_pkg::idx_t                     back_slot;

  logic                             ram_we;
  dq_pkg::idx_t                     ram_addr;
  logic [dq_pkg::DATA_W-1:0]        ram_rdata;

  // Ring arithmetic: tail_sum stays below twice the capacity; back_sum does too unless empty
  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_FULL);
  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - 1'b1;
  assign front_inc = (front_r == IDX_LAST) ? '0 : front_r + 1'b1;
  assign tail_sum  = {{(dq_pkg::CNT_W + 1 - dq_pkg::IDX_W){1'b0}}, front_r}
                   + {1'b0, count_r};
  assign back_sum  = tail_sum - 1'b1;
  assign tail_slot = (tail_sum >= SUM_CAP) ? dq_pkg::IDX_W'(tail_sum - SUM_CAP)
                                           : dq_pkg::IDX_W'(tail_sum);
  assign back_slot = (back_sum >= SUM_CAP) ? dq_pkg::IDX_W'(back_sum - SUM_CAP)
                                           : dq_pkg::IDX_W'(back_sum);

  // Operation decode: store access, pointer update, status
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = front_r;
    front_nxt = front_r;
    count_nxt = count_r;
    sts_nxt   = dq_pkg::ST_DONE;
    case (op_r)
      dq_pkg::OP_PUSH_FRONT: begin
        ram_addr = front_dec;
        if (full) begin
          sts_nxt = dq_pkg::ST_FULL;
        end else begin
          ram_we    = cmd.exec;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        ram_addr = front_r;
        if (empty) begin
          sts_nxt = dq_pkg::ST_EMPTY;
        end else begin
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        ram_addr = tail_slot;
        if (full) begin
          sts_nxt = dq_pkg::ST_FULL;
        end else begin
          ram_we    = cmd.exec;
          count_nxt = count_r + 1'b1;
        end
      end
      default: begin
        ram_addr = back_slot;
        if (empty) begin
          sts_nxt = dq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
    endcase
  end

  // Hold the pointers; advance them on execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Capture the item and the outcome
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_item.operation;
      value_r <= in_item.push_value;
    end
    if (cmd.exec) begin
      sts_r <= sts_nxt;
    end
  end

  dq_ram #(
    .WIDTH (dq_pkg::DATA_W),
    .DEPTH (dq_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (value_r),
    .rdata (ram_rdata)
  );

  assign dp_sts.pop_hit = (op_r inside {dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK})
                          && (sts_r == dq_pkg::ST_DONE);

  // Result: store data for a successful pop, minus one otherwise
  assign out_item.pop_value = cmd.sel_ram ? ram_rdata : dq_pkg::NEG_ONE;
  assign out_item.status    = sts_r;

`ifndef NO_ASSERTIONS
  // Fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count beyond capacity");

  // Pointers move only on execute
  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.exec)) |-> ($stable(count_r) && $stable(front_r)))
    else $error("pointer moved without execute");

  // A refused push leaves the count untouched
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (sts_nxt == dq_pkg::ST_FULL)) |=> (count_r == CNT_FULL))
    else $error("count changed on refused push");
`endif

endmodule
